// ===== hw/rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer: parse phases,
// the result record, status codes and header length codes.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Parse phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_LEN     = 6'b000010,
        PH_EXT     = 6'b000100,
        PH_KEY     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT_BUF = 3'd1;
    localparam logic [2:0] ST_HDR_TRUNC = 3'd2;
    localparam logic [2:0] ST_BAD_OP    = 3'd3;
    localparam logic [2:0] ST_PAY_SHORT = 3'd4;

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Extended length and key byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Smallest buffer that is not reported as too short
    localparam logic [2:0] MIN_BUF_BYTES = 3'd4;

    // Result queue
    localparam int          RQ_DEPTH = 4;
    localparam logic [2:0]  RQ_FULL  = 3'd4;
    localparam logic [2:0]  RQ_ROOM  = 3'd2;

    // Bounds of the valid opcode ranges
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // One result transaction
    typedef struct packed {
        logic        kind;
        logic [7:0]  pbyte;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] length;
        logic [2:0]  status;
        logic        last;
    } t_result;

    function automatic logic opcode_ok(input logic [3:0] op);
        return (op <= OP_BIN) || ((op >= OP_CLOSE) && (op <= OP_PONG));
    endfunction

endpackage

// ===== hw/rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses the header of a received WebSocket frame, unmasks its payload and
// reports one status per buffer.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per clock while o_stall is low. The header,
// extended length and masking key are parsed as they arrive; each payload
// byte is written to the result queue, XORed with its key byte. The last byte
// of a buffer adds a status transaction (fin, opcode, mask flag, length and
// error code) after any payload byte. Results pass through a four-entry queue:
// o_stall rises while fewer than two slots are free, so a sustained rate of
// one byte per cycle holds as long as the output is not stalled; a buffer
// end that falls inside the payload yields two results.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_start,
    input  logic        i_buffer_end,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_fin_bit,
    output logic [3:0]  o_frame_opcode,
    output logic        o_was_masked,
    output logic [63:0] o_payload_length,
    output logic [2:0]  o_frame_status,
    output logic        o_last_result
);

    // Frame state
    t_phase      r_phase,     n_phase;
    logic [2:0]  r_byte_cnt,  n_byte_cnt;
    logic        r_fin,       n_fin;
    logic [3:0]  r_opcode,    n_opcode;
    logic        r_masked,    n_masked;
    logic [3:0]  r_ext_left,  n_ext_left;
    logic [63:0] r_length,    n_length;
    logic [63:0] r_remaining, n_remaining;
    logic [31:0] r_mask_key,  n_mask_key;
    logic [1:0]  r_mask_idx,  n_mask_idx;

    // Result queue
    t_result     r_rq [RQ_DEPTH];
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_count,  n_count;

    logic        in_acc, out_acc;
    logic        clr;
    t_phase      cur_phase;
    logic        len_done, key_done, pay_emit;
    logic [3:0]  ext_dec;
    logic [63:0] rem_dec;
    logic [7:0]  key_byte;
    logic [2:0]  stat;
    t_result     res_pay, res_stat, res_first;
    logic [1:0]  push_n;

    assign in_acc  = i_valid & ~o_stall;
    assign out_acc = o_valid & ~i_stall;
    assign o_stall = (r_count > RQ_ROOM);
    assign o_valid = (r_count != 3'd0);

    // Parse one byte: next frame state and the results it causes
    assign clr       = i_buffer_start | (r_phase == PH_IDLE);
    assign cur_phase = clr ? PH_IDLE : r_phase;

    always_comb begin
        n_phase     = r_phase;
        n_byte_cnt  = r_byte_cnt;
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        n_ext_left  = r_ext_left;
        n_length    = r_length;
        n_remaining = r_remaining;
        n_mask_key  = r_mask_key;
        n_mask_idx  = r_mask_idx;
        len_done    = 1'b0;
        key_done    = 1'b0;
        pay_emit    = 1'b0;
        key_byte    = 8'd0;
        ext_dec     = 4'd0;
        rem_dec     = 64'd0;
        stat        = ST_OK;

        // drop frame state at a buffer start or when idle
        if (clr) begin
            n_phase     = PH_IDLE;
            n_byte_cnt  = 3'd0;
            n_fin       = 1'b0;
            n_opcode    = 4'd0;
            n_masked    = 1'b0;
            n_ext_left  = 4'd0;
            n_length    = 64'd0;
            n_remaining = 64'd0;
            n_mask_key  = 32'd0;
            n_mask_idx  = 2'd0;
        end

        // count buffer bytes, saturating
        if (n_byte_cnt < MIN_BUF_BYTES) begin
            n_byte_cnt = n_byte_cnt + 3'd1;
        end

        unique case (cur_phase)
            PH_IDLE: begin
                n_fin    = i_data_byte[7];
                n_opcode = i_data_byte[3:0];
                n_phase  = PH_LEN;
            end
            PH_LEN: begin
                n_masked = i_data_byte[7];
                n_length = 64'd0;
                if (i_data_byte[6:0] == LEN_CODE_EXT16) begin
                    n_ext_left = EXT16_BYTES;
                    n_phase    = PH_EXT;
                end else if (i_data_byte[6:0] == LEN_CODE_EXT64) begin
                    n_ext_left = EXT64_BYTES;
                    n_phase    = PH_EXT;
                end else begin
                    n_length = {57'd0, i_data_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_EXT: begin
                n_length   = {n_length[55:0], i_data_byte};
                ext_dec    = n_ext_left - 4'd1;
                n_ext_left = ext_dec;
                len_done   = (ext_dec == 4'd0);
            end
            PH_KEY: begin
                n_mask_key = {n_mask_key[23:0], i_data_byte};
                ext_dec    = n_ext_left - 4'd1;
                n_ext_left = ext_dec;
                key_done   = (ext_dec == 4'd0);
            end
            PH_PAYLOAD: begin
                pay_emit = 1'b1;
                if (n_masked) begin
                    case (n_mask_idx)
                        2'd0:    key_byte = n_mask_key[31:24];
                        2'd1:    key_byte = n_mask_key[23:16];
                        2'd2:    key_byte = n_mask_key[15:8];
                        default: key_byte = n_mask_key[7:0];
                    endcase
                end
                n_mask_idx  = n_mask_idx + 2'd1;
                rem_dec     = n_remaining - 64'd1;
                n_remaining = rem_dec;
                if (rem_dec == 64'd0) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                // ignore bytes after the payload
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // length known: take the key or start the payload
        if (len_done && n_masked) begin
            n_ext_left = KEY_BYTES;
            n_phase    = PH_KEY;
        end
        if ((len_done && !n_masked) || key_done) begin
            n_mask_idx  = 2'd0;
            n_remaining = n_length;
            n_phase     = (n_length != 64'd0) ? PH_PAYLOAD : PH_DONE;
        end

        // status, by priority
        if (n_byte_cnt < MIN_BUF_BYTES) begin
            stat = ST_SHORT_BUF;
        end else if ((n_phase == PH_LEN) || (n_phase == PH_EXT) || (n_phase == PH_KEY)) begin
            stat = ST_HDR_TRUNC;
        end else if (n_phase == PH_PAYLOAD) begin
            stat = ST_PAY_SHORT;
        end else if (!opcode_ok(n_opcode)) begin
            stat = ST_BAD_OP;
        end

        res_pay          = '0;
        res_pay.kind     = KIND_PAYLOAD;
        res_pay.pbyte    = i_data_byte ^ key_byte;
        res_pay.last     = ~i_buffer_end;

        res_stat         = '0;
        res_stat.kind    = KIND_STATUS;
        res_stat.fin     = n_fin;
        res_stat.opcode  = n_opcode;
        res_stat.masked  = n_masked;
        res_stat.length  = n_length;
        res_stat.status  = stat;
        res_stat.last    = 1'b1;

        // close the buffer after its status
        if (i_buffer_end) begin
            n_phase     = PH_IDLE;
            n_byte_cnt  = 3'd0;
            n_fin       = 1'b0;
            n_opcode    = 4'd0;
            n_masked    = 1'b0;
            n_ext_left  = 4'd0;
            n_length    = 64'd0;
            n_remaining = 64'd0;
            n_mask_key  = 32'd0;
            n_mask_idx  = 2'd0;
        end
    end

    assign res_first = pay_emit ? res_pay : res_stat;
    assign push_n    = in_acc ? ({1'b0, pay_emit} + {1'b0, i_buffer_end}) : 2'd0;
    assign n_count   = r_count + {1'b0, push_n} - {2'd0, out_acc};

    // Advance frame state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_byte_cnt  <= 3'd0;
            r_fin       <= 1'b0;
            r_opcode    <= 4'd0;
            r_masked    <= 1'b0;
            r_ext_left  <= 4'd0;
            r_length    <= 64'd0;
            r_remaining <= 64'd0;
            r_mask_key  <= 32'd0;
            r_mask_idx  <= 2'd0;
        end else if (in_acc) begin
            r_phase     <= n_phase;
            r_byte_cnt  <= n_byte_cnt;
            r_fin       <= n_fin;
            r_opcode    <= n_opcode;
            r_masked    <= n_masked;
            r_ext_left  <= n_ext_left;
            r_length    <= n_length;
            r_remaining <= n_remaining;
            r_mask_key  <= n_mask_key;
            r_mask_idx  <= n_mask_idx;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n;
            r_rd_ptr <= r_rd_ptr + {1'b0, out_acc};
            r_count  <= n_count;
        end
    end

    // Write up to two results per byte
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_rq[r_wr_ptr] <= res_first;
        end
        if (push_n == 2'd2) begin
            r_rq[r_wr_ptr + 2'd1] <= res_stat;
        end
    end

    // Present the queue head
    assign o_result_kind    = r_rq[r_rd_ptr].kind;
    assign o_payload_byte   = r_rq[r_rd_ptr].pbyte;
    assign o_fin_bit        = r_rq[r_rd_ptr].fin;
    assign o_frame_opcode   = r_rq[r_rd_ptr].opcode;
    assign o_was_masked     = r_rq[r_rd_ptr].masked;
    assign o_payload_length = r_rq[r_rd_ptr].length;
    assign o_frame_status   = r_rq[r_rd_ptr].status;
    assign o_last_result    = r_rq[r_rd_ptr].last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RQ_FULL)
        else $error("result queue overfilled");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) + {1'b0, $past(push_n)}
                            - {2'd0, $past(out_acc)}))
        else $error("queue count lost track of pushes and pops");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_remaining != 64'd0))
        else $error("payload phase with nothing remaining");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == KIND_STATUS)) |-> o_last_result)
        else $error("status transaction not marked last");

    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n == 2'd2) |-> (pay_emit && i_buffer_end))
        else $error("two results without a payload byte at buffer end");

endmodule
